>>> rtl/uyvy420_pkg.sv
// Shared types and constants for the UYVY to planar 4:2:0 chroma averager.
// No dependencies.
package uyvy420_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam int LP_W       = 11;
    localparam int FL_W       = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_PAIRS  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LINES = 1'b1;

    localparam logic [LP_W-1:0] LP_RESET = 11'd320;
    localparam logic [FL_W-1:0] FL_RESET = 13'd480;

    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    // u in the lowest byte, matching the input tdata packing
    typedef struct packed {
        logic [7:0] y1;
        logic [7:0] v;
        logic [7:0] y0;
        logic [7:0] u;
    } pix_t;

    typedef struct packed {
        logic fend;
        logic last_col;
        logic lower;
    } flags_t;

    localparam int PIX_W   = $bits(pix_t);
    localparam int FLAGS_W = $bits(flags_t);

endpackage

>>> rtl/uyvy420_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module uyvy420_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [W-1:0]                           wdata,
    output logic [W-1:0]                           rdata
);
    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/uyvy420_front.sv
// Front end: config registers, column/line counters, per-request classification.
// Depends on uyvy420_pkg.
module uyvy420_front #(
    parameter int MAX_LINE_PAIRS = 1024,
    parameter int MAX_LINES      = 4096
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [uyvy420_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [uyvy420_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  uyvy420_pkg::pix_t                      in_pix,
    input  logic                                   q_full,
    output logic                                   push,
    output uyvy420_pkg::pix_t                      push_pix,
    output uyvy420_pkg::flags_t                    push_flags,
    output logic [(MAX_LINE_PAIRS > 1 ? $clog2(MAX_LINE_PAIRS) : 1)-1:0] push_slot
);
    import uyvy420_pkg::*;

    localparam int CW  = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
    localparam int WW0 = $clog2(MAX_LINE_PAIRS + 1);
    localparam int XW  = (LP_W > WW0) ? LP_W : WW0;
    localparam int RW  = $clog2(MAX_LINES);
    localparam int YW0 = $clog2(MAX_LINES + 2);
    localparam int YW  = (FL_W > YW0) ? FL_W : YW0;

    logic [LP_W-1:0] line_pairs_reg, line_pairs_next;
    logic [FL_W-1:0] frame_lines_reg, frame_lines_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;

    logic [XW-1:0] lp_x, width_c;
    logic [YW-1:0] fl_x, lines_c;
    logic          last_col, last_row, near_end, lower, accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_comb begin
        line_pairs_next  = line_pairs_reg;
        frame_lines_next = frame_lines_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                REG_LINE_PAIRS:  line_pairs_next  = cfg_data[LP_W-1:0];
                REG_FRAME_LINES: frame_lines_next = cfg_data[FL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lp_x = XW'(line_pairs_reg);
        fl_x = YW'(frame_lines_reg);
        if (lp_x == '0) begin
            width_c = XW'(1);
        end else if (lp_x > XW'(MAX_LINE_PAIRS)) begin
            width_c = XW'(MAX_LINE_PAIRS);
        end else begin
            width_c = lp_x;
        end
        if (fl_x == '0) begin
            lines_c = YW'(1);
        end else if (fl_x > YW'(MAX_LINES)) begin
            lines_c = YW'(MAX_LINES);
        end else begin
            lines_c = fl_x;
        end
        last_col = (XW'(col_reg) + XW'(1)) >= width_c;
        last_row = (YW'(row_reg) + YW'(1)) >= lines_c;
        near_end = (YW'(row_reg) + YW'(2)) >= lines_c;
        lower    = row_reg[0];
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : RW'(row_reg + RW'(1));
            end else begin
                col_next = CW'(col_reg + CW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pairs_reg  <= LP_RESET;
            frame_lines_reg <= FL_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
        end else begin
            line_pairs_reg  <= line_pairs_next;
            frame_lines_reg <= frame_lines_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

    // unpaired last line is consumed without a request to the back end
    assign push                = accept && !(!lower && last_row);
    assign push_pix            = in_pix;
    assign push_flags.lower    = lower;
    assign push_flags.last_col = last_col;
    assign push_flags.fend     = lower && last_col && near_end;
    assign push_slot           = col_reg;
endmodule

>>> rtl/uyvy420_queue.sv
// Short FIFO decoupling the front end from the back end.
// Depends on uyvy420_pkg.
module uyvy420_queue #(
    parameter int W = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         q_valid,
    output logic [W-1:0] q_data
);
    import uyvy420_pkg::*;

    logic [W-1:0]    ent_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = ent_reg[rd_reg];

    always_comb begin
        wr_next  = push ? Q_AW'(wr_reg + Q_AW'(1)) : wr_reg;
        rd_next  = pop ? Q_AW'(rd_reg + Q_AW'(1)) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = (Q_AW+1)'(cnt_reg + (Q_AW+1)'(1));
        end else if (pop && !push) begin
            cnt_next = (Q_AW+1)'(cnt_reg - (Q_AW+1)'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= push_data;
        end
    end
endmodule

>>> rtl/uyvy420_back.sv
// Back end: chroma line store access, rounded averaging, output register.
// Depends on uyvy420_pkg and uyvy420_ram.
module uyvy420_back #(
    parameter int MAX_LINE_PAIRS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  uyvy420_pkg::pix_t    q_pix,
    input  uyvy420_pkg::flags_t  q_flags,
    input  logic [(MAX_LINE_PAIRS > 1 ? $clog2(MAX_LINE_PAIRS) : 1)-1:0] q_slot,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);
    import uyvy420_pkg::*;

    logic        p1_valid_reg, p1_valid_next;
    pix_t        p1_pix_reg;
    flags_t      p1_flags_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_last_reg;
    logic        p1_move;
    logic [15:0] kept;
    logic [8:0]  u_sum, v_sum;
    logic [7:0]  u_avg, v_avg;

    assign p1_move = p1_valid_reg && (!out_valid_reg || m_tready);
    assign pop     = q_valid && (!p1_valid_reg || p1_move);

    // upper line writes {u, v}; lower line reads the entry above
    uyvy420_ram #(
        .W     (16),
        .DEPTH (MAX_LINE_PAIRS)
    ) u_store (
        .aclk  (aclk),
        .en    (pop),
        .we    (!q_flags.lower),
        .addr  (q_slot),
        .wdata ({q_pix.u, q_pix.v}),
        .rdata (kept)
    );

    always_comb begin
        u_sum = 9'(kept[15:8]) + 9'(p1_pix_reg.u) + 9'd1;
        v_sum = 9'(kept[7:0]) + 9'(p1_pix_reg.v) + 9'd1;
        u_avg = p1_flags_reg.lower ? u_sum[8:1] : 8'd0;
        v_avg = p1_flags_reg.lower ? v_sum[8:1] : 8'd0;
    end

    always_comb begin
        p1_valid_next  = pop ? 1'b1 : (p1_move ? 1'b0 : p1_valid_reg);
        out_valid_next = p1_move ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            p1_pix_reg   <= q_pix;
            p1_flags_reg <= q_flags;
        end
        if (p1_move) begin
            out_data_reg <= {v_avg, u_avg, p1_pix_reg.y1, p1_pix_reg.y0};
            out_user_reg <= {p1_flags_reg.fend, p1_flags_reg.lower, p1_flags_reg.lower};
            out_last_reg <= p1_flags_reg.last_col;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
endmodule

>>> rtl/uyvy_to_planar_420_chroma_average.sv
// UYVY 4:2:2 to 4:2:0 converter: luma pass-through, vertical chroma averaging.
// Depends on uyvy420_pkg, uyvy420_front, uyvy420_queue, uyvy420_back.
//
// s_* takes one UYVY macropixel per request in raster order; m_* returns one
// result per macropixel, except for the unpaired last line of an odd-height
// frame, which is consumed silently. cfg_* writes line_pairs (index 0) and
// frame_lines (index 1); write only while the block is idle.
// Throughput is one macropixel per cycle while m_tready stays high: the front
// counters, the 4-entry queue and the single line store port each handle one
// request a cycle. An accepted request is written into the queue, then popped
// into the back end register together with the line store read, then moved
// into the output register that drives m_tvalid.
// When m_tready is low the output register holds and the back end stops;
// requests collect in the 4-entry queue and s_tready drops once it is full.
// Reset (aresetn low, synchronous) clears counters, queue and valid flags and
// restores line_pairs = 320, frame_lines = 480. The line store is not
// cleared; each lower-line entry is written by the upper line first.
module uyvy_to_planar_420_chroma_average #(
    parameter int MAX_LINE_PAIRS = 1024,
    parameter int MAX_LINES      = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uyvy420_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uyvy420_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // u_in, y0_in, v_in, y1_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,  // y_left, y_right, u_avg, v_avg
    output logic [2:0]                         m_tuser,  // second_line, chroma_valid, frame_end
    output logic                               m_tlast   // line_end
);
    import uyvy420_pkg::*;

    localparam int CW = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
    localparam int QW = PIX_W + FLAGS_W + CW;

    logic          q_full, push, pop, q_valid;
    pix_t          push_pix, q_pix;
    flags_t        push_flags, q_flags;
    logic [CW-1:0] push_slot, q_slot;
    logic [QW-1:0] q_data;

    uyvy420_front #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS),
        .MAX_LINES      (MAX_LINES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pix     (pix_t'(s_tdata)),
        .q_full     (q_full),
        .push       (push),
        .push_pix   (push_pix),
        .push_flags (push_flags),
        .push_slot  (push_slot)
    );

    uyvy420_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_slot, push_flags, push_pix}),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    assign q_pix   = pix_t'(q_data[PIX_W-1:0]);
    assign q_flags = flags_t'(q_data[PIX_W+FLAGS_W-1:PIX_W]);
    assign q_slot  = q_data[QW-1:PIX_W+FLAGS_W];

    uyvy420_back #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pix    (q_pix),
        .q_flags  (q_flags),
        .q_slot   (q_slot),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for uyvy_to_planar_420_chroma_average.
// Depends on uyvy420_pkg and the DUT; directed table first, then random frames,
// each result checked against a typed entry or a local model of store and counters.
module tb;
    import uyvy420_pkg::*;

    localparam int MAX_LP        = 1024;
    localparam int MAX_LN        = 4096;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [7:0] y_left;
        logic [7:0] y_right;
        logic       second_line;
        logic       chroma_valid;
        logic [7:0] u_avg;
        logic [7:0] v_avg;
        logic       line_end;
        logic       frame_end;
    } result_t;

    typedef enum {ROW_CFG, ROW_PIX, ROW_CHECKED, ROW_SILENT} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        int                    data;
        pix_t                  pix;
        result_t               res;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    uyvy_to_planar_420_chroma_average dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // model state
    logic [15:0] chroma_rows [MAX_LP];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned pairs_reg;
    int unsigned lines_reg;

    result_t     expected_results [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count;
    int          emitted_count;
    int          s_idle_pct;
    int          m_idle_pct;
    result_t     got_res;
    result_t     want_res;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // advances the model by one macropixel; returns 1 when a result is due
    function automatic bit chroma_average_step(input pix_t p, output result_t r);
        int unsigned w;
        int unsigned nl;
        int unsigned slot;
        bit          last_col;
        bit          last_row;
        bit          lower;
        bit          emits;
        logic [15:0] kept;
        logic [8:0]  su;
        logic [8:0]  sv;
        w        = clamp_dim(pairs_reg, MAX_LP);
        nl       = clamp_dim(lines_reg, MAX_LN);
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= nl);
        lower    = row_pos[0];
        emits    = lower || !last_row;
        r        = '0;
        if (emits) begin
            slot = (col_pos < MAX_LP) ? col_pos : MAX_LP - 1;
            r.y_left   = p.y0;
            r.y_right  = p.y1;
            r.line_end = last_col;
            if (!lower) begin
                chroma_rows[slot] = {p.u, p.v};
            end else begin
                kept = chroma_rows[slot];
                su   = 9'(kept[15:8]) + 9'(p.u) + 9'd1;
                sv   = 9'(kept[7:0]) + 9'(p.v) + 9'd1;
                r.second_line  = 1'b1;
                r.chroma_valid = 1'b1;
                r.u_avg        = su[8:1];
                r.v_avg        = sv[8:1];
                r.frame_end    = last_col && (row_pos + 2 >= nl);
            end
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return emits;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch: %s got %0h want %0h (result %0d)",
                 what, got, want, emitted_count);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{y_left: m_tdata[7:0], y_right: m_tdata[15:8],
                        second_line: m_tuser[0], chroma_valid: m_tuser[1],
                        u_avg: m_tdata[23:16], v_avg: m_tdata[31:24],
                        line_end: m_tlast, frame_end: m_tuser[2]};
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending", m_tdata[7:0], 8'h0);
            end else begin
                want_res = expected_results.pop_front();
                if (got_res.y_left !== want_res.y_left)
                    report_mismatch("y_left", got_res.y_left, want_res.y_left);
                if (got_res.y_right !== want_res.y_right)
                    report_mismatch("y_right", got_res.y_right, want_res.y_right);
                if (got_res.second_line !== want_res.second_line)
                    report_mismatch("second_line", 8'(got_res.second_line),
                                    8'(want_res.second_line));
                if (got_res.chroma_valid !== want_res.chroma_valid)
                    report_mismatch("chroma_valid", 8'(got_res.chroma_valid),
                                    8'(want_res.chroma_valid));
                if (got_res.u_avg !== want_res.u_avg)
                    report_mismatch("u_avg", got_res.u_avg, want_res.u_avg);
                if (got_res.v_avg !== want_res.v_avg)
                    report_mismatch("v_avg", got_res.v_avg, want_res.v_avg);
                if (got_res.line_end !== want_res.line_end)
                    report_mismatch("line_end", 8'(got_res.line_end),
                                    8'(want_res.line_end));
                if (got_res.frame_end !== want_res.frame_end)
                    report_mismatch("frame_end", 8'(got_res.frame_end),
                                    8'(want_res.frame_end));
            end
        end
    end

    // more = another write follows at once, so valid stays high
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input int d, input bit more);
        cfg_valid <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= d[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        if (!more) cfg_valid <= 1'b0;
        case (a)
            REG_LINE_PAIRS:  pairs_reg = d & 32'h7FF;
            REG_FRAME_LINES: lines_reg = d & 32'h1FFF;
            default: ;
        endcase
    endtask

    // typed expectation overrides the model's for checked rows; silent rows expect none
    task automatic send_pix(input pix_t p, input row_kind_t kind, input result_t typed);
        result_t r;
        bit      emits;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        emits = chroma_average_step(p, r);
        if (kind == ROW_CHECKED) begin
            expected_results.push_back(typed);
            emitted_count++;
        end else if (kind == ROW_PIX && emits) begin
            expected_results.push_back(r);
            emitted_count++;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_line();
        repeat (clamp_dim(pairs_reg, MAX_LP)) send_pix(pix_t'($urandom), ROW_PIX, '0);
    endtask

    // resizing only at the start of an upper line keeps every store read written
    task automatic run_frames(input int lp, input int fl, input int n, input bit hold);
        if (row_pos[0]) send_line();
        settle();
        write_reg(REG_LINE_PAIRS, lp, 1'b1);
        write_reg(REG_FRAME_LINES, fl, 1'b0);
        for (int i = 0; i < n; i++) begin
            if (hold && i == n / 2) settle();
            send_line();
        end
    endtask

    function automatic pix_t mk_pix(logic [7:0] u, logic [7:0] y0, logic [7:0] v,
                                    logic [7:0] y1);
        return '{y1: y1, v: v, y0: y0, u: u};
    endfunction

    function automatic result_t mk_res(logic [7:0] yl, logic [7:0] yr, logic sl,
                                       logic [7:0] ua, logic [7:0] va, logic le);
        return '{y_left: yl, y_right: yr, second_line: sl, chroma_valid: sl,
                 u_avg: ua, v_avg: va, line_end: le, frame_end: 1'b0};
    endfunction

    task automatic add_row(input row_kind_t k, input int a, input int d, input pix_t p,
                           input result_t r);
        stim_row_t row;
        row.kind = k;
        row.addr = a[CFG_ADDR_W-1:0];
        row.data = d;
        row.pix  = p;
        row.res  = r;
        directed_rows.push_back(row);
    endtask

    initial begin
        int phase;
        col_pos        = 0;
        row_pos        = 0;
        pairs_reg      = LP_RESET;
        lines_reg      = FL_RESET;
        mismatch_count = 0;
        emitted_count  = 0;
        s_idle_pct     = 35;
        m_idle_pct     = 74;
        for (int i = 0; i < MAX_LP; i++) chroma_rows[i] = '0;

        // reset sizes 320 x 480, upper line
        add_row(ROW_CHECKED, 0, 0, mk_pix(8'h00, 8'h00, 8'h00, 8'h00),
                mk_res(8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(ROW_CHECKED, 0, 0, mk_pix(8'hff, 8'hff, 8'hff, 8'hff),
                mk_res(8'hff, 8'hff, 1'b0, 8'h00, 8'h00, 1'b0));
        // shrink the line mid-line: next macropixel ends it
        add_row(ROW_CFG, REG_LINE_PAIRS, 3, '0, '0);
        add_row(ROW_CHECKED, 0, 0, mk_pix(8'h80, 8'h12, 8'h7f, 8'h34),
                mk_res(8'h12, 8'h34, 1'b0, 8'h00, 8'h00, 1'b1));
        // lower line: averages round up
        add_row(ROW_CHECKED, 0, 0, mk_pix(8'hff, 8'ha5, 8'h00, 8'h5a),
                mk_res(8'ha5, 8'h5a, 1'b1, 8'h80, 8'h00, 1'b0));
        add_row(ROW_CHECKED, 0, 0, mk_pix(8'hff, 8'h00, 8'hff, 8'hff),
                mk_res(8'h00, 8'hff, 1'b1, 8'hff, 8'hff, 1'b0));
        add_row(ROW_PIX, 0, 0, mk_pix(8'h00, 8'h0f, 8'hff, 8'hf0), '0);
        // odd height: unpaired last line is swallowed
        add_row(ROW_CFG, REG_FRAME_LINES, 3, '0, '0);
        add_row(ROW_SILENT, 0, 0, mk_pix(8'h55, 8'haa, 8'h55, 8'haa), '0);
        add_row(ROW_SILENT, 0, 0, mk_pix(8'haa, 8'h55, 8'haa, 8'h55), '0);
        add_row(ROW_SILENT, 0, 0, mk_pix(8'h01, 8'h02, 8'h03, 8'h04), '0);
        // zero width acts as one
        add_row(ROW_CFG, REG_LINE_PAIRS, 0, '0, '0);
        add_row(ROW_CFG, REG_FRAME_LINES, 2, '0, '0);
        add_row(ROW_PIX, 0, 0, mk_pix(8'hc3, 8'h3c, 8'h96, 8'h69), '0);
        add_row(ROW_PIX, 0, 0, mk_pix(8'h3d, 8'hc2, 8'h69, 8'h96), '0);
        // zero height acts as one: nothing emitted
        add_row(ROW_CFG, REG_FRAME_LINES, 0, '0, '0);
        add_row(ROW_SILENT, 0, 0, mk_pix(8'h7e, 8'h81, 8'h18, 8'he7), '0);
        add_row(ROW_CFG, REG_LINE_PAIRS, 2, '0, '0);
        add_row(ROW_CFG, REG_FRAME_LINES, 4, '0, '0);
        add_row(ROW_PIX, 0, 0, mk_pix(8'h01, 8'hfe, 8'h02, 8'hfd), '0);
        add_row(ROW_PIX, 0, 0, mk_pix(8'hfe, 8'h01, 8'hfd, 8'h02), '0);
        add_row(ROW_PIX, 0, 0, mk_pix(8'h10, 8'hef, 8'h20, 8'hdf), '0);
        add_row(ROW_PIX, 0, 0, mk_pix(8'hef, 8'h10, 8'hdf, 8'h20), '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CFG) settle();
                write_reg(directed_rows[i].addr, directed_rows[i].data,
                          i + 1 < directed_rows.size() &&
                          directed_rows[i+1].kind == ROW_CFG);
            end else begin
                send_pix(directed_rows[i].pix, directed_rows[i].kind, directed_rows[i].res);
            end
        end

        phase = 0;
        while (emitted_count < 360) begin
            if (emitted_count >= 240) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else if (emitted_count >= 120) begin
                s_idle_pct = 74;
                m_idle_pct = 35;
            end
            run_frames(($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9),
                       $urandom_range(0, 9), $urandom_range(1, 8), (phase % 3) == 0);
            phase++;
        end

        // oversize height register acts as the limit
        run_frames(3, 8191, 3, 1'b0);

        settle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
